// ===== design/rdf_pkg.sv =====
// Shared types, codes and the CRC-8 step for the register datagram framer.
// No dependencies; every other design file imports this package.
package rdf_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;

    localparam logic [3:0] WRITE_LEN   = 4'd8;
    localparam logic [3:0] READ_LEN    = 4'd4;
    localparam logic [3:0] REPLY_LAST  = 4'd7;
    localparam logic [3:0] REPLY_DATA0 = 4'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
    localparam logic [2:0] READ_LAST_IDX  = 3'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  node_address;
        logic [7:0]  register_index;
        logic [31:0] write_value;
        logic [7:0]  line_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] reply_value;
        logic        crc_ok;
    } out_item_t;

    // Work handed from front to back: a datagram, a reply or a reject.
    typedef struct packed {
        logic [1:0]  kind;
        logic        is_write;
        logic [7:0]  node_address;
        logic [7:0]  register_index;
        logic [31:0] value;
        logic        crc_ok;
    } job_t;

    // One byte into the CRC, LSB first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/rdf_front.sv =====
// Front end: accepts input beats, checks requests, tracks echo and reply gathering.
// Depends on rdf_pkg.
module rdf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             q_full,
    input  rdf_pkg::in_item_t request,
    output logic             full,
    output logic             job_push,
    output rdf_pkg::job_t    job
);
    import rdf_pkg::*;

    logic [3:0]  echo_left_reg, echo_left_next;
    logic        awaiting_reg, awaiting_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] shift_reg, shift_next;

    logic accept;
    logic is_req;
    logic bad_req;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign is_req = (request.command == CMD_WRITE) || (request.command == CMD_READ);
    assign bad_req = (request.node_address[7:2] != 6'd0) || request.register_index[7];

    always_comb
    begin
        echo_left_next = echo_left_reg;
        awaiting_next  = awaiting_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        shift_next     = shift_reg;
        job_push       = 1'b0;
        job            = '0;
        if (accept) begin
            if (is_req) begin
                job_push = 1'b1;
                if (bad_req) begin
                    job.kind = KIND_REJECT;
                end else begin
                    job.kind           = KIND_TX;
                    job.is_write       = (request.command == CMD_WRITE);
                    job.node_address   = request.node_address;
                    job.register_index = request.register_index;
                    job.value          = request.write_value;
                    echo_left_next = (request.command == CMD_WRITE) ? WRITE_LEN : READ_LEN;
                    awaiting_next  = (request.command == CMD_READ);
                    count_next     = '0;
                    crc_next       = '0;
                    shift_next     = '0;
                end
            end else if (request.command == CMD_RX) begin
                if (echo_left_reg != 4'd0) begin
                    echo_left_next = echo_left_reg - 4'd1;
                end else if (awaiting_reg) begin
                    if (count_reg < REPLY_LAST) begin
                        crc_next   = crc_feed(crc_reg, request.line_byte);
                        count_next = count_reg + 4'd1;
                        if (count_reg >= REPLY_DATA0) begin
                            shift_next = {shift_reg[23:0], request.line_byte};
                        end
                    end else begin
                        job_push      = 1'b1;
                        job.kind      = KIND_REPLY;
                        job.value     = shift_reg;
                        job.crc_ok    = (request.line_byte == crc_reg);
                        awaiting_next = 1'b0;
                        count_next    = '0;
                        crc_next      = '0;
                        shift_next    = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            echo_left_reg <= '0;
            awaiting_reg  <= 1'b0;
            count_reg     <= '0;
            crc_reg       <= '0;
            shift_reg     <= '0;
        end else begin
            echo_left_reg <= echo_left_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            shift_reg     <= shift_next;
        end
    end

`ifndef SYNTHESIS
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !awaiting_reg |-> (count_reg == 4'd0))
        else $error("reply count nonzero while no reply pending");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= REPLY_LAST)
        else $error("reply count overran");
    a_no_job_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !job_push)
        else $error("job issued into full queue");
`endif
endmodule

// ===== design/rdf_fifo.sv =====
// Two-entry job queue between front and back.
// Depends on rdf_pkg.
module rdf_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rdf_pkg::job_t wdata,
    input  logic          pop,
    output rdf_pkg::job_t rdata,
    output logic          full,
    output logic          empty
);
    import rdf_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd0) || (count_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
`endif
endmodule

// ===== design/rdf_back.sv =====
// Back end: expands jobs into result beats, builds datagram CRC, holds output register.
// Depends on rdf_pkg.
module rdf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rdf_pkg::job_t      job,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output rdf_pkg::out_item_t result
);
    import rdf_pkg::*;

    job_t      job_reg;
    logic      active_reg, active_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] crc_reg, crc_next;
    logic      out_valid_reg;
    out_item_t out_reg;

    logic      out_free;
    logic      beat_go;
    logic      beat_last;
    logic [2:0] last_idx;
    logic [7:0] frame_byte;
    out_item_t beat;

    assign out_free = !out_valid_reg || pop;
    assign beat_go  = active_reg && out_free;
    assign last_idx = job_reg.is_write ? WRITE_LAST_IDX : READ_LAST_IDX;
    assign beat_last = (job_reg.kind != KIND_TX) || (idx_reg == last_idx);
    assign q_pop    = !q_empty && (!active_reg || (beat_go && beat_last));

    always_comb
    begin
        frame_byte = crc_reg;
        if (idx_reg != last_idx) begin
            case (idx_reg)
                3'd0: frame_byte = SYNC_BYTE;
                3'd1: frame_byte = job_reg.node_address;
                3'd2: frame_byte = job_reg.register_index
                                   | (job_reg.is_write ? WRITE_FLAG : 8'h00);
                3'd3: frame_byte = job_reg.value[31:24];
                3'd4: frame_byte = job_reg.value[23:16];
                3'd5: frame_byte = job_reg.value[15:8];
                3'd6: frame_byte = job_reg.value[7:0];
                default: frame_byte = crc_reg;
            endcase
        end
    end

    always_comb
    begin
        beat      = '0;
        beat.kind = job_reg.kind;
        beat.last = beat_last;
        if (job_reg.kind == KIND_TX) begin
            beat.tx_byte = frame_byte;
        end else if (job_reg.kind == KIND_REPLY) begin
            beat.reply_value = job_reg.value;
            beat.crc_ok      = job_reg.crc_ok;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (q_pop) begin
            active_next = 1'b1;
            idx_next    = '0;
            crc_next    = '0;
        end else if (beat_go) begin
            if (beat_last) begin
                active_next = 1'b0;
            end
            idx_next = idx_reg + 3'd1;
            crc_next = crc_feed(crc_reg, frame_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            job_reg <= job;
        end
        if (beat_go) begin
            out_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            if (beat_go) begin
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (job_reg.kind == KIND_TX)) |-> (idx_reg <= last_idx))
        else $error("datagram index past frame end");
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind != KIND_TX)) |-> out_reg.last)
        else $error("reply or reject beat without last");
    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_TX))
            |-> ((out_reg.reply_value == 32'd0) && !out_reg.crc_ok))
        else $error("transmit beat carries reply fields");
`endif
endmodule

// ===== design/register_datagram_framer_crc8.sv =====
// Top level of the register datagram framer: front end, job queue, back end.
// Depends on rdf_pkg, rdf_front, rdf_fifo, rdf_back.
//
//  channel   handshake        payload              beats
//  request   push / full      rdf_pkg::in_item_t   one per command or line byte
//  result    pop / empty      rdf_pkg::out_item_t  8 per write, 4 per read, 1 per reject or reply
//
// A request beat is taken every cycle while the two-entry job queue has room.
// The back end emits one result beat per cycle while the output register is free, so a write yields 8 beats, a read 4.
// Reply, reject and line bytes are classified combinationally by the front end.
// Reset clears all control state; there is no clearing pass.
// A stalled result holds in the output register; the queue absorbs front-end beats.
module register_datagram_framer_crc8 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rdf_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output rdf_pkg::out_item_t result
);
    import rdf_pkg::*;

    job_t front_job;
    job_t q_job;
    logic job_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    rdf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_full   (q_full),
        .request  (request),
        .full     (full),
        .job_push (job_push),
        .job      (front_job)
    );

    rdf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (front_job),
        .pop   (q_pop),
        .rdata (q_job),
        .full  (q_full),
        .empty (q_empty)
    );

    rdf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (q_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ===== tb/rdf_datagram_checker.sv =====
// Checker for register_datagram_framer_crc8: watches request and result beats,
// predicts datagram, reply and reject beats, and counts mismatches.
// Depends on rdf_pkg.
module rdf_datagram_checker
    import rdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  request,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        pending,
    output int        fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ADDR_LIMIT = 8'd4;
    localparam logic [7:0] REG_LIMIT  = 8'd128;

    out_item_t   owed_beats[$];
    logic [3:0]  echo_skip;
    logic        reply_armed;
    logic [3:0]  reply_pos;
    logic [7:0]  reply_crc;
    logic [31:0] reply_word;

    function automatic logic [7:0] crc8_lsb_first(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic out_item_t make_beat(input logic [1:0] k, input logic [7:0] tx,
                                            input logic lst, input logic [31:0] val,
                                            input logic ok);
        out_item_t b;
        b.kind        = k;
        b.tx_byte     = tx;
        b.last        = lst;
        b.reply_value = val;
        b.crc_ok      = ok;
        return b;
    endfunction

    task automatic clear_reply();
        reply_pos  = '0;
        reply_crc  = '0;
        reply_word = '0;
    endtask

    task automatic predict_datagram(input in_item_t it);
        logic [7:0] frame [8];
        int         len;
        logic [7:0] crc;
        case (it.command)
            CMD_WRITE, CMD_READ:
            begin
                if (it.node_address >= ADDR_LIMIT || it.register_index >= REG_LIMIT) begin
                    owed_beats.push_back(make_beat(KIND_REJECT, 8'h00, 1'b1, 32'h0, 1'b0));
                end else begin
                    frame[0] = SYNC_BYTE;
                    frame[1] = it.node_address;
                    if (it.command == CMD_WRITE) begin
                        frame[2] = it.register_index | WRITE_FLAG;
                        frame[3] = it.write_value[31:24];
                        frame[4] = it.write_value[23:16];
                        frame[5] = it.write_value[15:8];
                        frame[6] = it.write_value[7:0];
                        len = 7;
                    end else begin
                        frame[2] = it.register_index;
                        len = 3;
                    end
                    crc = 8'h00;
                    for (int i = 0; i < len; i++) begin
                        crc = crc8_lsb_first(crc, frame[i]);
                    end
                    frame[len] = crc;
                    len++;
                    for (int i = 0; i < len; i++) begin
                        owed_beats.push_back(make_beat(KIND_TX, frame[i], i == len - 1,
                                                       32'h0, 1'b0));
                    end
                    echo_skip   = len[3:0];
                    reply_armed = (it.command == CMD_READ);
                    clear_reply();
                end
            end
            CMD_RX:
            begin
                if (echo_skip != 4'd0) begin
                    echo_skip = echo_skip - 4'd1;
                end else if (reply_armed) begin
                    if (reply_pos < REPLY_LAST) begin
                        reply_crc = crc8_lsb_first(reply_crc, it.line_byte);
                        if (reply_pos >= REPLY_DATA0) begin
                            reply_word = {reply_word[23:0], it.line_byte};
                        end
                        reply_pos = reply_pos + 4'd1;
                    end else begin
                        owed_beats.push_back(make_beat(KIND_REPLY, 8'h00, 1'b1, reply_word,
                                                       it.line_byte == reply_crc));
                        reply_armed = 1'b0;
                        clear_reply();
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (owed_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", got.kind);
            fail_count++;
        end else begin
            want = owed_beats.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
            check_field("last", 32'(want.last), 32'(got.last));
            check_field("reply_value", want.reply_value, got.reply_value);
            check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            owed_beats.delete();
            echo_skip   = '0;
            reply_armed = 1'b0;
            clear_reply();
            fail_count  = 0;
            pending    <= 0;
        end else begin
            if (pop && !empty) begin
                check_beat(result);
            end
            if (push && !full) begin
                predict_datagram(request);
            end
            pending <= owed_beats.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the register_datagram_framer_crc8 testbench: clock, reset, request
// stimulus, result draining, watchdog and verdict. Depends on rdf_pkg and
// rdf_datagram_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdf_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_GOAL    = 480;
    localparam int DRAIN_CYCLES = 30;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    in_item_t  request = '0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        pending;
    int        fail_count;

    int beats_sent   = 0;
    bit steady       = 1'b0;
    bit draining     = 1'b0;
    int quiet_cycles = 0;

    register_datagram_framer_crc8 u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    rdf_datagram_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.command        = 2'($urandom);
        it.node_address   = 8'($urandom);
        it.register_index = 8'($urandom);
        it.write_value    = $urandom;
        it.line_byte      = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99) < 38) begin
            push <= 1'b0;
            @(posedge clk);
        end
        request <= it;
        push    <= 1'b1;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        if (it.command != CMD_NONE) begin
            beats_sent++;
        end
        steady = (beats_sent >= 90 && beats_sent < 200);
    endtask

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic [7:0] reg_idx, input logic [31:0] value);
        in_item_t it;
        it                = random_item();
        it.command        = cmd;
        it.node_address   = addr;
        it.register_index = reg_idx;
        it.write_value    = value;
        send_item(it);
    endtask

    task automatic send_line(input logic [7:0] b);
        in_item_t it;
        it           = random_item();
        it.command   = CMD_RX;
        it.line_byte = b;
        send_item(it);
    endtask

    task automatic send_line_bytes(input int n);
        repeat (n) send_line(8'($urandom));
    endtask

    task automatic send_reject();
        in_item_t it;
        it         = random_item();
        it.command = $urandom_range(1) ? CMD_READ : CMD_WRITE;
        if ($urandom_range(1)) begin
            it.register_index[7] = 1'b1;
        end else begin
            it.node_address[7:2] = 6'($urandom_range(1, 63));
        end
        send_item(it);
    endtask

    // reply of up to 8 beats, count of them sent; a reject may be slipped in before beat reject_at
    task automatic send_reply(input bit good, input int count, input int reject_at);
        logic [7:0] bytes [8];
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < 7; i++) begin
            bytes[i] = 8'($urandom);
            crc = rdf_pkg::crc_feed(crc, bytes[i]);
        end
        bytes[7] = good ? crc : crc ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < count; i++) begin
            if (i == reject_at) begin
                send_reject();
            end
            send_line(bytes[i]);
        end
    endtask

    task automatic random_sequence();
        int       pick;
        int       n;
        int       cut;
        in_item_t it;
        pick = $urandom_range(99);
        if (pick < 28) begin
            send_request(CMD_WRITE, 8'($urandom_range(3)), 8'($urandom_range(127)), $urandom);
            send_line_bytes(($urandom_range(7) == 0) ? int'($urandom_range(7)) : 8);
        end else if (pick < 70) begin
            send_request(CMD_READ, 8'($urandom_range(3)), 8'($urandom_range(127)), $urandom);
            n = ($urandom_range(9) == 0) ? int'($urandom_range(3)) : 4;
            send_line_bytes(n);
            if (n == 4) begin
                cut = ($urandom_range(7) == 0) ? int'($urandom_range(7)) : 8;
                send_reply($urandom_range(9) < 7, cut,
                           ($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1);
            end
        end else if (pick < 82) begin
            send_reject();
        end else if (pick < 94) begin
            send_line_bytes($urandom_range(1, 3));
        end else begin
            it         = random_item();
            it.command = CMD_NONE;
            send_item(it);
        end
    endtask

    initial
    begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && beats_sent >= 110) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= draining || steady || ($urandom_range(99) >= 38);
        end
    end

    initial
    begin
        in_item_t it;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // stray line beat at reset, unused command
        send_line(8'h00);
        it         = random_item();
        it.command = CMD_NONE;
        send_item(it);
        // read cut short by writes at the field extremes
        send_request(CMD_READ, 8'd2, 8'd5, 32'h0);
        send_request(CMD_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send_request(CMD_WRITE, 8'd3, 8'd127, 32'hFFFF_FFFF);
        // rejects leave the pending echo alone
        send_request(CMD_WRITE, 8'd4, 8'd0, $urandom);
        send_request(CMD_READ, 8'd255, 8'd255, $urandom);
        send_request(CMD_READ, 8'd0, 8'd128, $urandom);
        // full read with echo and a good reply
        send_request(CMD_READ, 8'd3, 8'd127, $urandom);
        send_line_bytes(4);
        send_reply(1'b1, 8, -1);

        while (beats_sent < ITEM_GOAL) begin
            random_sequence();
        end

        push    <= 1'b0;
        draining = 1'b1;
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
